// File: rtl/core/bmp_to_framebuffer_blit_macros.svh
// Assertion macros shared by the blitter RTL.
`ifndef BMP_TO_FRAMEBUFFER_BLIT_MACROS_SVH
`define BMP_TO_FRAMEBUFFER_BLIT_MACROS_SVH
`ifndef SYNTH
`define BFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFB_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BFB_ASSERT(label, clk, rst_n, prop, msg)
`define BFB_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/core/bfb_pkg.sv
// ---------------------------------------------------------------------------
// bfb_pkg
// Shared types and constants of the BMP to framebuffer blitter.
// ---------------------------------------------------------------------------
package bfb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 800;
  localparam int DEF_SCREEN_HEIGHT = 480;

  // screen coordinate widths before clipping: origin plus image counter
  localparam int SX_W = 11;
  localparam int SY_W = 10;

  localparam int FIFO_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SCALE   = 3'd4;

  localparam logic [9:0] RST_IMAGE_WIDTH  = 10'd800;
  localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd480;

  typedef struct packed {
    logic [9:0] image_width;
    logic [8:0] image_height;
    logic [9:0] origin_x;
    logic [8:0] origin_y;
    logic       half_scale;
  } cfg_t;

  // one on-screen pixel handed from front to back
  typedef struct packed {
    logic [SX_W-1:0] sx;
    logic [SY_W-1:0] sy;
    logic [23:0]     color;
  } pix_t;

endpackage

// File: rtl/core/bfb_in_if.sv
// ---------------------------------------------------------------------------
// bfb_in_if
// Byte channel into the blitter: valid/ready, a start-of-image flag and one pixel-data byte.
// ---------------------------------------------------------------------------
interface bfb_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_image;
  logic [7:0] data_byte;

  modport source (output valid, output start_of_image, output data_byte, input ready);
  modport sink   (input valid, input start_of_image, input data_byte, output ready);
endinterface

// File: rtl/core/bfb_out_if.sv
// ---------------------------------------------------------------------------
// bfb_out_if
// Framebuffer write channel out of the blitter: valid/ready, address, color.
// ---------------------------------------------------------------------------
interface bfb_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] fb_address;
  logic [23:0] pixel_color;

  modport source (output valid, output fb_address, output pixel_color, input ready);
  modport sink   (input valid, input fb_address, input pixel_color, output ready);
endinterface

// File: rtl/core/bfb_fifo.sv
// ---------------------------------------------------------------------------
// bfb_fifo
// Short pixel queue between the byte front end and the address back end.
// ---------------------------------------------------------------------------
`include "bmp_to_framebuffer_blit_macros.svh"

module bfb_fifo import bfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pix_t push_data,
  input  logic pop,
  output pix_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  pix_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `BFB_NEVER(a_no_push_full, clk, rst_n, push && full, "push into full queue")
  `BFB_NEVER(a_no_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
  `BFB_NEVER(a_count_range, clk, rst_n, count_r > CNT_W'(FIFO_DEPTH), "queue count overflow")

endmodule

// File: rtl/core/bfb_front.sv
// ---------------------------------------------------------------------------
// bfb_front
// Byte front end: assembles B,G,R bytes, skips row padding, tracks the
// image column and row, and queues only pixels that land on the screen.
// ---------------------------------------------------------------------------
module bfb_front import bfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  bfb_in_if.sink     in_bytes,
  input  logic       q_full,
  output logic       q_push,
  output pix_t       q_data
);

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_e;
  logic [9:0]  col_r, col_nxt, col_e;
  logic [8:0]  row_r, row_nxt, row_e;
  logic [1:0]  pad_r, pad_nxt, pad_e;
  logic [15:0] held_r, held_nxt, held_e;

  logic            acc;
  logic            restart;
  logic [10:0]     col_inc;
  logic [9:0]      width_e;
  logic            visible;
  logic [SX_W-1:0] sx;
  logic [SY_W-1:0] sy;

  assign in_bytes.ready = !q_full;
  assign acc            = in_bytes.valid && !q_full;
  assign restart        = in_bytes.start_of_image;

  always_comb begin
    phase_e = restart ? PH_BLUE : phase_r;
    col_e   = restart ? '0 : col_r;
    row_e   = restart ? '0 : row_r;
    pad_e   = restart ? '0 : pad_r;
    held_e  = restart ? '0 : held_r;

    phase_nxt = phase_e;
    col_nxt   = col_e;
    row_nxt   = row_e;
    pad_nxt   = pad_e;
    held_nxt  = held_e;

    width_e = (cfg.image_width == '0) ? 10'd1 : cfg.image_width;
    col_inc = {1'b0, col_e} + 11'd1;

    if (cfg.half_scale) begin
      visible = !col_e[0] && !row_e[0];
      sx      = {2'b00, col_e[9:1]};
      sy      = {2'b00, row_e[8:1]};
    end else begin
      visible = 1'b1;
      sx      = {1'b0, cfg.origin_x} + {1'b0, col_e};
      sy      = {1'b0, cfg.origin_y} + {1'b0, row_e};
    end

    q_push       = 1'b0;
    q_data.sx    = sx;
    q_data.sy    = sy;
    q_data.color = {in_bytes.data_byte, held_e};

    priority if (row_e >= cfg.image_height) begin
      // image done: ignore bytes until the next start
    end else if (pad_e != '0) begin
      pad_nxt = pad_e - 2'd1;
    end else begin
      unique case (phase_e)
        PH_BLUE: begin
          held_nxt  = {held_e[15:8], in_bytes.data_byte};
          phase_nxt = PH_GREEN;
        end
        PH_GREEN: begin
          held_nxt  = {in_bytes.data_byte, held_e[7:0]};
          phase_nxt = PH_RED;
        end
        default: begin
          phase_nxt = PH_BLUE;
          if (col_inc >= {1'b0, width_e}) begin
            col_nxt = '0;
            row_nxt = row_e + 9'd1;
            // 3*w padded to 4 bytes: pad is w mod 4
            pad_nxt = width_e[1:0];
          end else begin
            col_nxt = col_inc[9:0];
          end
          q_push = visible && (32'(sx) < SCREEN_WIDTH) && (32'(sy) < SCREEN_HEIGHT);
        end
      endcase
    end

    if (!acc) begin
      phase_nxt = phase_r;
      col_nxt   = col_r;
      row_nxt   = row_r;
      pad_nxt   = pad_r;
      held_nxt  = held_r;
      q_push    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLUE;
      col_r   <= '0;
      row_r   <= '0;
      pad_r   <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pad_r   <= pad_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// File: rtl/core/bfb_back.sv
// ---------------------------------------------------------------------------
// bfb_back
// Address back end: row-from-top times screen width, plus column, into a
// registered framebuffer write.
// ---------------------------------------------------------------------------
`include "bmp_to_framebuffer_blit_macros.svh"

module bfb_back import bfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  pix_t       q_data,
  output logic       q_pop,
  bfb_out_if.source  out_pixels
);

  localparam int WW = $clog2(SCREEN_WIDTH + 1);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int PW = WW + RW;
  localparam int AW = (PW + 1 > 19) ? PW + 1 : 19;

  logic [RW-1:0]   row_top;
  logic [PW-1:0]   s1_prod_r;
  logic [SX_W-1:0] s1_sx_r;
  logic [23:0]     s1_color_r;
  logic            s1_v_r;
  logic [AW-1:0]   addr_sum;
  logic [18:0]     o_addr_r;
  logic [23:0]     o_color_r;
  logic            o_v_r;
  logic            o_adv;
  logic            s1_adv;

  assign o_adv  = !o_v_r || out_pixels.ready;
  assign s1_adv = !s1_v_r || o_adv;
  assign q_pop  = !q_empty && s1_adv;

  assign row_top  = RW'(SCREEN_HEIGHT - 1) - RW'(q_data.sy);
  assign addr_sum = AW'(s1_prod_r) + AW'(s1_sx_r);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_prod_r  <= PW'(SCREEN_WIDTH) * PW'(row_top);
      s1_sx_r    <= q_data.sx;
      s1_color_r <= q_data.color;
    end
    if (o_adv) begin
      o_addr_r  <= addr_sum[18:0];
      o_color_r <= s1_color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= q_pop;
      end
      if (o_adv) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  assign out_pixels.valid       = o_v_r;
  assign out_pixels.fb_address  = o_addr_r;
  assign out_pixels.pixel_color = o_color_r;

  `BFB_ASSERT(a_s1_hold, clk, rst_n, s1_v_r && !o_adv |=> s1_v_r && $stable(s1_prod_r), "stage lost")
  `BFB_ASSERT(a_pop_load, clk, rst_n, q_pop |=> s1_v_r, "popped pixel not in stage")
  `BFB_ASSERT(a_out_load, clk, rst_n, o_adv && s1_v_r |=> o_v_r, "stage not moved to output")

endmodule

// File: rtl/core/bmp_to_framebuffer_blit.sv
// ---------------------------------------------------------------------------
// bmp_to_framebuffer_blit
// 24-bit bottom-up BMP pixel bytes in, framebuffer writes out.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while the pixel queue is not full; at most one framebuffer write per cycle.
// Path: the pixel completed by an accepted red byte passes the queue entry, the
//   multiply stage and the output register, in that order.
// A four-entry pixel queue lets the byte side run while the output stalls.
// Reset: registers go to 800/480/0/0/0, counters to zero, queue and stages empty.
module bmp_to_framebuffer_blit import bfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bfb_in_if.sink                in_bytes,
  bfb_out_if.source             out_pixels
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_pop, q_full, q_empty;
  pix_t q_wdata, q_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data;
        CFG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data[8:0];
        CFG_ORIGIN_X:     cfg_nxt.origin_x     = cfg_data;
        CFG_ORIGIN_Y:     cfg_nxt.origin_y     = cfg_data[8:0];
        CFG_HALF_SCALE:   cfg_nxt.half_scale   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.half_scale   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_bytes (in_bytes),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  bfb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  bfb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_pixels (out_pixels)
  );

endmodule

// File: tb/sv/bmp_to_framebuffer_blit_tb.sv
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit_tb
// Self-checking bench for the BMP pixel-byte to framebuffer blitter. A queue of
// pixel-data bytes feeds a clocked driver. Accepted bytes run through a local
// model of the blitter, and a clocked monitor checks each framebuffer write
// against the oldest predicted one. Register settings change between phases,
// and both handshake sides idle at random.
// ----------------------------------------------------------------------------
module bmp_to_framebuffer_blit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfb_pkg::*;

  localparam int IDLE_PCT      = 22;
  localparam int LONG_STALL    = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 950;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } bmp_byte_t;

  typedef struct packed {
    logic [18:0] addr;
    logic [23:0] color;
  } fb_write_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfb_in_if  in_if ();
  bfb_out_if out_if ();

  bmp_to_framebuffer_blit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_bytes   (in_if),
    .out_pixels (out_if)
  );

  bmp_byte_t byte_stream[$];
  fb_write_t fb_writes_due[$];

  int  bytes_queued;
  int  error_count;
  int  cycle_count;
  int  stall_asked;
  int  stall_served;
  int  stall_left;
  bit  quiet;
  bit  byte_taken;

  // model registers
  logic [9:0] img_width;
  logic [8:0] img_height;
  logic [9:0] org_x;
  logic [8:0] org_y;
  logic       half_mode;

  // model counters
  logic [1:0]  byte_phase;
  logic [9:0]  col_cnt;
  logic [8:0]  row_cnt;
  logic [1:0]  pad_left;
  logic [15:0] held_bg;

  function automatic void clear_counters();
    byte_phase = '0;
    col_cnt    = '0;
    row_cnt    = '0;
    pad_left   = '0;
    held_bg    = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    case (idx)
      CFG_IMAGE_WIDTH:  img_width  = 10'(value);
      CFG_IMAGE_HEIGHT: img_height = 9'(value);
      CFG_ORIGIN_X:     org_x      = 10'(value);
      CFG_ORIGIN_Y:     org_y      = 9'(value);
      CFG_HALF_SCALE:   half_mode  = value[0];
      default: ;
    endcase
  endfunction

  // Advance the model by one byte; returns 1 when the byte completes an
  // on-screen pixel.
  function automatic bit blit_byte(input logic sof, input logic [7:0] b,
                                   output fb_write_t wr);
    int span, col, row, sx, sy;
    bit on_screen;
    wr = '0;
    if (sof) clear_counters();
    if (row_cnt >= img_height) return 0;
    if (pad_left != 2'd0) begin
      pad_left = pad_left - 2'd1;
      return 0;
    end
    if (byte_phase == 2'd0) begin
      held_bg[7:0] = b;
      byte_phase = 2'd1;
      return 0;
    end
    if (byte_phase == 2'd1) begin
      held_bg[15:8] = b;
      byte_phase = 2'd2;
      return 0;
    end
    col = col_cnt;
    row = row_cnt;
    byte_phase = 2'd0;
    span = (img_width == 10'd0) ? 1 : int'(img_width);
    // a column at or past the width (after a width change) also ends the row
    if (col + 1 >= span) begin
      col_cnt  = '0;
      row_cnt  = row_cnt + 9'd1;
      pad_left = 2'((4 - ((span * 3) & 3)) & 3);
    end else begin
      col_cnt = 10'(col + 1);
    end
    if (half_mode) begin
      on_screen = (col[0] == 1'b0) && (row[0] == 1'b0);
      sx = col >> 1;
      sy = row >> 1;
    end else begin
      on_screen = 1'b1;
      sx = int'(org_x) + col;
      sy = int'(org_y) + row;
    end
    if (!on_screen || sx >= DEF_SCREEN_WIDTH || sy >= DEF_SCREEN_HEIGHT) return 0;
    wr.addr  = 19'(DEF_SCREEN_WIDTH * (DEF_SCREEN_HEIGHT - 1 - sy) + sx);
    wr.color = {b, held_bg};
    return 1;
  endfunction

  // bytes in a full image: rows padded to 4 bytes
  function automatic int image_bytes(input int w, input int h);
    int span;
    span = (w == 0) ? 1 : w;
    return h * ((span * 3 + 3) & ~3);
  endfunction

  function automatic void push_byte(input logic sof, input logic [7:0] data);
    bmp_byte_t b;
    b.sof  = sof;
    b.data = data;
    byte_stream.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void queue_random(input int n);
    for (int k = 0; k < n; k++) push_byte(1'b0, 8'($urandom));
  endfunction

  // cut > 0 truncates the image after that many bytes
  function automatic void queue_image(input int w, input int h, input int cut,
                                      input int extra);
    int total;
    total = (h == 0) ? $urandom_range(3, 12) : image_bytes(w, h);
    if (cut > 0 && cut < total) total = cut;
    push_byte(1'b1, 8'($urandom));
    queue_random(total - 1);
    queue_random(extra);
  endfunction

  task automatic wait_idle();
    while (byte_stream.size() != 0 || in_if.valid || fb_writes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic set_config(input int w, input int h, input int ox, input int oy,
                            input int hs);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_HALF_SCALE, hs);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin : byte_driver
    bmp_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || byte_taken) begin
      if (byte_stream.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = byte_stream.pop_front();
        in_if.valid          <= 1'b1;
        in_if.start_of_image <= nxt.sof;
        in_if.data_byte      <= nxt.data;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : write_sink
    if (stall_asked != stall_served) begin
      stall_served = stall_asked;
      stall_left   = LONG_STALL;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : write_monitor
    fb_write_t predicted;
    fb_write_t seen;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (blit_byte(in_if.start_of_image, in_if.data_byte, predicted))
          fb_writes_due.push_back(predicted);
      end
      if (out_if.valid && out_if.ready) begin
        seen.addr  = out_if.fb_address;
        seen.color = out_if.pixel_color;
        if (fb_writes_due.size() == 0) begin
          $error("unexpected write: fb_address %0d pixel_color %06h", seen.addr, seen.color);
          error_count++;
        end else begin
          predicted = fb_writes_due.pop_front();
          if (seen.addr !== predicted.addr) begin
            $error("fb_address: expected %0d, got %0d", predicted.addr, seen.addr);
            error_count++;
          end
          if (seen.color !== predicted.color) begin
            $error("pixel_color: expected %06h, got %06h", predicted.color, seen.color);
            error_count++;
          end
        end
      end
    end
    byte_taken = in_if.valid && in_if.ready;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[bmp_to_framebuffer_blit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int w, h, ox, oy, hs, n_img, cut, base;
    in_if.valid          = 1'b0;
    in_if.start_of_image = 1'b0;
    in_if.data_byte      = '0;
    out_if.ready         = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    bytes_queued = 0;
    error_count  = 0;
    stall_asked  = 0;
    stall_served = 0;
    stall_left   = 0;
    quiet        = 1'b0;
    byte_taken   = 1'b0;
    img_width    = RST_IMAGE_WIDTH;
    img_height   = RST_IMAGE_HEIGHT;
    org_x        = '0;
    org_y        = '0;
    half_mode    = 1'b0;
    clear_counters();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: all-zero then all-ones pixel at the bottom-left
    push_byte(1'b1, 8'h00);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'hFF);
    wait_idle();

    // 1x1 image with one pad byte, then bytes past the end are dropped
    set_config(1, 1, 0, 0, 0);
    queue_image(1, 1, 0, 2);
    wait_idle();

    // zero width behaves as one
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    queue_image(0, 2, 0, 0);
    wait_idle();

    // zero height: nothing comes out
    write_reg(CFG_IMAGE_HEIGHT, 0);
    queue_image(1, 0, 3, 0);
    wait_idle();

    // top-right corner, second row falls off the top
    set_config(1, 2, 799, 479, 0);
    queue_image(1, 2, 0, 0);
    wait_idle();

    // half mode, origin ignored
    set_config(2, 2, 5, 5, 1);
    queue_image(2, 2, 0, 0);
    wait_idle();

    // width shrinks mid-row: the next pixel ends the row
    set_config(6, 2, 0, 0, 0);
    queue_image(6, 2, 9, 0);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 2);
    queue_random(11);
    wait_idle();

    base = bytes_queued;
    while (bytes_queued - base < RANDOM_ITEMS) begin
      w = $urandom_range(1, 12);
      if ($urandom_range(19) == 0) w = 0;
      else if ($urandom_range(19) == 0) w = $urandom_range(13, 64);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(2))
        0: begin ox = $urandom_range(0, 16);    oy = $urandom_range(0, 8);     end
        1: begin ox = $urandom_range(780, 799); oy = $urandom_range(470, 479); end
        default: begin ox = $urandom_range(0, 799); oy = $urandom_range(0, 479); end
      endcase
      hs = $urandom_range(1);
      set_config(w, h, ox, oy, hs);
      // resume with the old counters under the new settings
      if ($urandom_range(4) == 0) queue_random($urandom_range(1, 20));
      n_img = $urandom_range(1, 3);
      repeat (n_img) begin
        cut = ($urandom_range(4) == 0) ? $urandom_range(1, image_bytes(w, h) + 1) : 0;
        queue_image(w, h, cut, $urandom_range(0, 3));
      end
      wait_idle();
    end

    // output held off while bytes keep coming, then a pause mid-image
    set_config(8, 6, 0, 0, 0);
    queue_image(8, 6, image_bytes(8, 3), 0);
    stall_asked++;
    wait_idle();
    queue_random(image_bytes(8, 3));
    wait_idle();

    // back-to-back rows with no idling on either side
    quiet = 1'b1;
    set_config(32, 2, 0, 0, 0);
    queue_image(32, 2, 0, 0);
    wait_idle();
    quiet = 1'b0;

    // single column near the top, upper rows fall off the screen
    set_config(1, 16, 0, 470, 0);
    queue_image(1, 16, 0, 0);
    wait_idle();

    // odd width in half mode, cut in its second row
    set_config(63, 2, 10, 3, 1);
    queue_image(63, 2, image_bytes(63, 1) + 60, 0);
    wait_idle();

    if (error_count == 0)
      $display("[bmp_to_framebuffer_blit] OK");
    else
      $display("[bmp_to_framebuffer_blit] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bfb_pkg.sv
rtl/core/bfb_in_if.sv
rtl/core/bfb_out_if.sv
rtl/core/bfb_fifo.sv
rtl/core/bfb_front.sv
rtl/core/bfb_back.sv
rtl/core/bmp_to_framebuffer_blit.sv
tb/sv/bmp_to_framebuffer_blit_tb.sv
